// ===== design/scheduled_zone_thermostat_defines.svh =====
// ----------------------------------------------------------------------------
// scheduled_zone_thermostat_defines.svh
// Assertion macros used by the checker of the zone thermostat.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_ZONE_THERMOSTAT_DEFINES_SVH
`define SCHEDULED_ZONE_THERMOSTAT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SZT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SZT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Same-cycle implication that is also checked around reset.
`define SZT_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

// ===== design/szt_pkg.sv =====
// ----------------------------------------------------------------------------
// szt_pkg
// Types, constants and register codes of the scheduled zone thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package szt_pkg;

    // Sizes of the schedule store.
    localparam int ZONES          = 8;
    localparam int SLOTS_PER_WEEK = 672;
    localparam int TEMP_BITS      = 12;
    localparam int ADDR_W         = $clog2(ZONES * SLOTS_PER_WEEK);
    localparam int MEM_DEPTH      = ZONES * SLOTS_PER_WEEK;

    // Width that holds a target plus or minus the half band.
    localparam int CMP_W = TEMP_BITS + 2;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port sizes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_SP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK   = 2'd3;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic signed [TEMP_BITS-1:0] temp_t;

    // One input item.
    typedef struct packed {
        logic        command;
        logic [2:0]  zone;
        logic [9:0]  slot;
        temp_t       temp_value;
        logic [31:0] now_s;
        logic        switch_linked;
        logic        switch_action;
        logic [31:0] switch_date_s;
        logic [31:0] remote_date_s;
        temp_t       remote_setpoint;
        logic        sensor_present;
    } req_item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] out_zone;
        logic       write_ack;
        logic       heater_on;
        temp_t      target_setpoint;
    } rsp_item_t;

    // Configuration registers.
    typedef struct packed {
        logic [7:0]  band_half;
        logic [15:0] override_window_s;
        temp_t       boost_setpoint;
        temp_t       fallback_temp;
    } cfg_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic              is_write;
        logic [2:0]        zone;
        logic              zone_ok;
        logic              sched_ok;
        logic [ADDR_W-1:0] addr;
        logic              use_ovr;
        temp_t             ovr_target;
        temp_t             value;
    } job_t;

endpackage

`default_nettype wire

// ===== design/scheduled_zone_thermostat.sv =====
// ----------------------------------------------------------------------------
// scheduled_zone_thermostat
// Multi-zone heater controller with weekly schedules and hysteresis.
//
//   Channel  Handshake            Payload      Direction
//   req      req_valid/req_stall  req_item     into the block
//   rsp      rsp_valid/rsp_stall  rsp_item     out of the block
//   cfg      cfg_we               cfg_index,   into the block
//                                 cfg_data
//
// An item passes through the front register and at least one queue entry;
// the back then loads a write's result straight into the result register,
// while an evaluation first takes the registered read of the schedule memory.
// The back sets the sustained rate: one write per cycle while the result is
// not stalled; an evaluation holds the back busy until its result is loaded.
// Reset clears the heater bits and the queue and loads the register defaults;
// the schedule memory is not cleared and holds nothing until written.
// A stalled result leaves the front and the queue free to take items until
// the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_zone_thermostat (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire szt_pkg::req_item_t                 req_item,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output szt_pkg::rsp_item_t                      rsp_item,
    input  wire logic                               cfg_we,
    input  wire logic [szt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [szt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import szt_pkg::*;

    cfg_t cfg_reg;
    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic q_valid;
    job_t q_job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_half         <= 8'd8;
            cfg_reg.override_window_s <= 16'd3600;
            cfg_reg.boost_setpoint    <= 12'sd336;
            cfg_reg.fallback_temp     <= 12'sd304;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BAND_HALF:  cfg_reg.band_half         <= cfg_data[7:0];
                CFG_OVR_WINDOW: cfg_reg.override_window_s <= cfg_data;
                CFG_BOOST_SP:   cfg_reg.boost_setpoint    <= cfg_data[TEMP_BITS-1:0];
                CFG_FALLBACK:   cfg_reg.fallback_temp     <= cfg_data[TEMP_BITS-1:0];
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Front: accept and classify.
    szt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Queue between front and back.
    szt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // Back: memory, heater bits and results.
    szt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

// ===== design/szt_front.sv =====
// ----------------------------------------------------------------------------
// szt_front
// Accepts items, checks ranges, forms the store address and settles the
// override target and the measured temperature.
// ----------------------------------------------------------------------------
`default_nettype none

module szt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire szt_pkg::req_item_t req_item,
    input  wire szt_pkg::cfg_t     cfg,
    input  wire logic              q_full,
    output logic                   push,
    output szt_pkg::job_t          push_job
);
    import szt_pkg::*;

    logic        front_valid_reg;
    job_t        job_reg;
    job_t        job_next;
    logic        accept;
    logic [31:0] remote_age;
    logic [31:0] switch_age;
    logic        remote_recent;
    logic        switch_recent;

    // Handshake toward the source and toward the queue.
    assign req_stall = front_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_job  = job_reg;

    // Ages are taken modulo 2^32.
    assign remote_age    = req_item.now_s - req_item.remote_date_s;
    assign switch_age    = req_item.now_s - req_item.switch_date_s;
    assign remote_recent = remote_age < {16'd0, cfg.override_window_s};
    assign switch_recent = switch_age < {16'd0, cfg.override_window_s};

    // Classify the incoming item.
    always_comb
    begin
        job_next.is_write = (req_item.command == CMD_WRITE);
        job_next.zone     = req_item.zone;
        job_next.zone_ok  = 32'(req_item.zone) < ZONES;
        job_next.sched_ok = job_next.zone_ok && (32'(req_item.slot) < SLOTS_PER_WEEK);
        job_next.addr     = ADDR_W'(32'(req_item.zone) * SLOTS_PER_WEEK
                                    + 32'(req_item.slot));
        job_next.use_ovr    = 1'b0;
        job_next.ovr_target = req_item.remote_setpoint;
        if (remote_recent)
        begin
            job_next.use_ovr    = 1'b1;
            job_next.ovr_target = req_item.remote_setpoint;
        end
        else if (req_item.switch_linked && req_item.switch_action && switch_recent)
        begin
            job_next.use_ovr    = 1'b1;
            job_next.ovr_target = cfg.boost_setpoint;
        end
        // Setpoint for a write; measurement, or the fallback without a sensor, for an evaluation.
        if (job_next.is_write || req_item.sensor_present)
        begin
            job_next.value = req_item.temp_value;
        end
        else
        begin
            job_next.value = cfg.fallback_temp;
        end
    end

    // Holding register of the front stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            front_valid_reg <= 1'b1;
            job_reg         <= job_next;
        end
        else if (push)
        begin
            front_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/szt_queue.sv =====
// ----------------------------------------------------------------------------
// szt_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module szt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire szt_pkg::job_t push_job,
    output logic               q_full,
    input  wire logic          pop,
    output logic               q_valid,
    output szt_pkg::job_t      q_job
);
    import szt_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_full  = (32'(count_reg) == QDEPTH);
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/szt_back.sv =====
// ----------------------------------------------------------------------------
// szt_back
// Schedule memory, heater bits and hysteresis decision; drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module szt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire szt_pkg::cfg_t     cfg,
    input  wire logic              q_valid,
    input  wire szt_pkg::job_t     q_job,
    output logic                   pop,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output szt_pkg::rsp_item_t     rsp_item
);
    import szt_pkg::*;

    typedef enum logic {ST_IDLE, ST_EVAL} state_t;

    state_t    state_reg;
    job_t      job_reg;
    temp_t     rd_data_reg;
    logic      heat_reg [ZONES];
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;
    temp_t     sched_mem [MEM_DEPTH];

    logic                    out_free;
    logic                    rsp_load;
    temp_t                   target;
    logic signed [CMP_W-1:0] target_ext;
    logic signed [CMP_W-1:0] meas_ext;
    logic signed [CMP_W-1:0] band_ext;
    logic signed [CMP_W-1:0] low_lim;
    logic signed [CMP_W-1:0] high_lim;
    logic                    held;
    logic                    heat_next;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign pop       = (state_reg == ST_IDLE) && q_valid && out_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // A new result enters the output register in this cycle.
    assign rsp_load = (pop && q_job.is_write) || ((state_reg == ST_EVAL) && out_free);

    // Schedule memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (pop && q_job.is_write && q_job.sched_ok)
        begin
            sched_mem[q_job.addr] <= q_job.value;
        end
        if (pop && !q_job.is_write && q_job.sched_ok)
        begin
            rd_data_reg <= sched_mem[q_job.addr];
        end
    end

    // Target selection and hysteresis compare.
    always_comb
    begin
        if (job_reg.use_ovr)
        begin
            target = job_reg.ovr_target;
        end
        else if (job_reg.sched_ok)
        begin
            target = rd_data_reg;
        end
        else
        begin
            target = '0;
        end
        target_ext = CMP_W'(target);
        meas_ext   = CMP_W'(job_reg.value);
        band_ext   = signed'(CMP_W'(cfg.band_half));
        low_lim    = target_ext - band_ext;
        high_lim   = target_ext + band_ext;
        held       = job_reg.zone_ok ? heat_reg[job_reg.zone] : 1'b0;
        if (meas_ext < low_lim)
        begin
            heat_next = 1'b1;
        end
        else if (meas_ext > high_lim)
        begin
            heat_next = 1'b0;
        end
        else
        begin
            heat_next = held;
        end
    end

    // Sequencer, heater bits and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ZONES; i++)
            begin
                heat_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_job.is_write)
                        begin
                            rsp_valid_reg            <= 1'b1;
                            rsp_reg.out_zone         <= q_job.zone;
                            rsp_reg.write_ack        <= 1'b1;
                            rsp_reg.heater_on        <= 1'b0;
                            rsp_reg.target_setpoint  <= '0;
                        end
                        else
                        begin
                            job_reg   <= q_job;
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_EVAL:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg           <= 1'b1;
                        rsp_reg.out_zone        <= job_reg.zone;
                        rsp_reg.write_ack       <= 1'b0;
                        rsp_reg.heater_on       <= heat_next;
                        rsp_reg.target_setpoint <= target;
                        if (job_reg.zone_ok)
                        begin
                            heat_reg[job_reg.zone] <= heat_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/szt_checker.sv =====
// ----------------------------------------------------------------------------
// szt_checker
// Port-level checks of the zone thermostat, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scheduled_zone_thermostat_defines.svh"

module szt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    input  wire logic                               req_stall,
    input  wire szt_pkg::req_item_t                 req_item,
    input  wire logic                               rsp_valid,
    input  wire logic                               rsp_stall,
    input  wire szt_pkg::rsp_item_t                 rsp_item,
    input  wire logic                               cfg_we,
    input  wire logic [szt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [szt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import szt_pkg::*;

    // A stalled result item holds its value.
    `SZT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

    // Write acknowledgments carry no heater demand and no target.
    `SZT_ASSERT_NOW(a_ack_zero, rsp_valid && rsp_item.write_ack, !rsp_item.heater_on && (rsp_item.target_setpoint == '0))

    // Just out of reset the block shows no result and takes items.
    `SZT_ASSERT_ALWAYS(a_reset_quiet, $past(rst_n) == 1'b0, !rsp_valid && !req_stall)

    // The input side only begins to stall right after it took an item.
    `SZT_ASSERT_NOW(a_stall_cause, $rose(req_stall), $past(req_valid && !req_stall))

endmodule

bind scheduled_zone_thermostat szt_checker u_szt_checker (.*);

`default_nettype wire
